FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds on every clock edge outside reset
`define TMVG_ASSERT(name, clock, resetn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
// Check that a condition never holds outside reset
`define TMVG_ASSERT_NEVER(name, clock, resetn, cond, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) !(cond)) else $error(msg);
`else
`define TMVG_ASSERT(name, clock, resetn, prop, msg)
`define TMVG_ASSERT_NEVER(name, clock, resetn, cond, msg)
`endif

`endif

FILE: hdl/tmvg_pkg.sv
// ----------------------------------------------------------------------------
// Torus mesh vertex generator package
// Widths, register codes, sine coefficients and the lane types of the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmvg_pkg;

    // Field and register widths
    localparam int CNT_W      = 9;
    localparam int IDX_W      = 8;
    localparam int RAD_W      = 16;
    localparam int VIDX_W     = 16;
    localparam int PX_W       = 18;
    localparam int PY_W       = 17;
    localparam int PHASE_W    = 16;
    localparam int REM_W      = 9;
    localparam int CFG_IDX_W  = 2;

    // Cell chain sizes
    localparam int DIV_STEPS    = 16;
    localparam int DIV_LANES    = 2;
    localparam int HORNER_STEPS = 4;
    localparam int TRIG_LANES   = 4;

    // Constants
    localparam int LEAST_POINTS = 3;
    localparam int QUARTER_TURN = 16384;
    localparam int COEF_SHIFT   = 30;

    // Parameter defaults
    localparam int DEF_MAX_MINOR_POINTS = 256;
    localparam int DEF_MAX_MAJOR_POINTS = 256;
    localparam int DEF_TRIG_FRAC_BITS   = 15;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MINOR_RADIUS = 2'd0,
        REG_MAJOR_RADIUS = 2'd1,
        REG_MINOR_POINTS = 2'd2,
        REG_MAJOR_POINTS = 2'd3
    } cfg_reg_t;

    // Odd Taylor terms of a quarter-wave sine, Q30
    localparam logic [31:0] SINE_COEF [HORNER_STEPS+1] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
    };

    // One lane of the phase divider: partial remainder and dividend/quotient bits
    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [PHASE_W-1:0] low;
    } div_lane_t;

    // One lane of the sine evaluation
    typedef struct packed {
        logic [30:0] t;
        logic [30:0] t2;
        logic [31:0] acc;
        logic        neg;
    } trig_lane_t;

    // Index results that travel beside the arithmetic
    typedef struct packed {
        logic              in_range;
        logic [VIDX_W-1:0] self_idx;
        logic [VIDX_W-1:0] next_minor;
        logic [VIDX_W-1:0] next_major;
        logic [VIDX_W-1:0] next_both;
    } side_t;

endpackage

FILE: hdl/torus_mesh_vertex_generator.sv
// Throughput: one vertex per cycle; every stage advances together whenever the
// output register is empty or its result is taken in that cycle.
// The depth is set by the 16-cell phase divider chain, the sine Horner chain and the stages around them.
// Reset clears the pipeline valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// Torus mesh vertex generator
// Position and neighbor indices of one torus grid vertex per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module torus_mesh_vertex_generator #(
    parameter int MAX_MINOR_POINTS = tmvg_pkg::DEF_MAX_MINOR_POINTS,
    parameter int MAX_MAJOR_POINTS = tmvg_pkg::DEF_MAX_MAJOR_POINTS,
    parameter int TRIG_FRAC_BITS   = tmvg_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [tmvg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tmvg_pkg::RAD_W-1:0]            cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tmvg_pkg::IDX_W-1:0]            major_index,
    input  logic [tmvg_pkg::IDX_W-1:0]            minor_index,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tmvg_pkg::PX_W-1:0]      pos_x,
    output logic signed [tmvg_pkg::PY_W-1:0]      pos_y,
    output logic signed [tmvg_pkg::PX_W-1:0]      pos_z,
    output logic [tmvg_pkg::VIDX_W-1:0]           self_index,
    output logic [tmvg_pkg::VIDX_W-1:0]           next_minor_index,
    output logic [tmvg_pkg::VIDX_W-1:0]           next_major_index,
    output logic [tmvg_pkg::VIDX_W-1:0]           next_both_index,
    output logic                                  in_range
);
    import tmvg_pkg::*;

    localparam int F    = TRIG_FRAC_BITS;
    localparam int LAST = DIV_STEPS + HORNER_STEPS + 8;
    localparam int SH   = COEF_SHIFT - F;

    localparam logic [33:0]   S_HALF   = (34'(1) << SH) >> 1;
    localparam logic [F-1:0]  TRIG_TOP = '1;
    localparam logic [F+18:0] R_HALF   = ((F+19)'(1) << (F - 8)) >> 1;
    localparam logic [F+18:0] Y_HALF   = (F+19)'(1) << (F - 1);
    localparam logic [F+27:0] X_HALF   = (F+28)'(1) << (F + 7);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] minor_radius_reg;
    logic [RAD_W-1:0] major_radius_reg;
    logic [CNT_W-1:0] minor_points_reg;
    logic [CNT_W-1:0] major_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minor_radius_reg <= RAD_W'(256);
            major_radius_reg <= RAD_W'(512);
            minor_points_reg <= CNT_W'(16);
            major_points_reg <= CNT_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MINOR_RADIUS: minor_radius_reg <= cfg_data;
                REG_MAJOR_RADIUS: major_radius_reg <= cfg_data;
                REG_MINOR_POINTS: minor_points_reg <= cfg_data[CNT_W-1:0];
                REG_MAJOR_POINTS: major_points_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // Clamp point counts to the supported range
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] m_eff;

    always_comb
    begin
        if (minor_points_reg < CNT_W'(LEAST_POINTS))
            n_eff = CNT_W'(LEAST_POINTS);
        else if (32'(minor_points_reg) > MAX_MINOR_POINTS)
            n_eff = CNT_W'(MAX_MINOR_POINTS);
        else
            n_eff = minor_points_reg;

        if (major_points_reg < CNT_W'(LEAST_POINTS))
            m_eff = CNT_W'(LEAST_POINTS);
        else if (32'(major_points_reg) > MAX_MAJOR_POINTS)
            m_eff = CNT_W'(MAX_MAJOR_POINTS);
        else
            m_eff = major_points_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic  advance;
    logic  vld_reg  [LAST+1];
    side_t side_reg [LAST];

    assign advance  = !vld_reg[LAST] || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Input stage: neighbor indices and divider seeds
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   i_ext;
    logic [CNT_W-1:0]   j_ext;
    logic [CNT_W-1:0]   j_wrap;
    logic [16:0]        base;
    logic [16:0]        nbase;
    logic               row_last;
    logic               range_c;
    side_t              side_c;
    div_lane_t [DIV_LANES-1:0] div_seed;

    always_comb
    begin
        i_ext    = {1'b0, major_index};
        j_ext    = {1'b0, minor_index};
        range_c  = (i_ext < m_eff) && (j_ext < n_eff);
        j_wrap   = (j_ext + CNT_W'(1) == n_eff) ? '0 : j_ext + CNT_W'(1);
        row_last = (i_ext + CNT_W'(1) == m_eff);
        base     = 17'(major_index) * 17'(n_eff);
        nbase    = base + 17'(n_eff);

        side_c.in_range   = range_c;
        side_c.self_idx   = VIDX_W'(base + 17'(j_ext));
        side_c.next_minor = VIDX_W'(base + 17'(j_wrap));
        side_c.next_major = row_last ? VIDX_W'(j_ext)  : VIDX_W'(nbase + 17'(j_ext));
        side_c.next_both  = row_last ? VIDX_W'(j_wrap) : VIDX_W'(nbase + 17'(j_wrap));
        if (!range_c)
        begin
            side_c = '0;
        end

        // phase = (k * 65536 + c / 2) / c, k sits above the low 16 bits
        div_seed[0].rem = j_ext;
        div_seed[0].low = PHASE_W'(n_eff >> 1);
        div_seed[1].rem = i_ext;
        div_seed[1].low = PHASE_W'(m_eff >> 1);
    end

    div_lane_t [DIV_LANES-1:0] div_bus [DIV_STEPS+1];
    logic [DIV_LANES-1:0][CNT_W-1:0] divisor;

    assign divisor = {m_eff, n_eff};

    // Hold the input stage and the side pipeline
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_bus[0]  <= div_seed;
            side_reg[0] <= side_c;
            for (int k = 1; k < LAST; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Phase divider chain
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        tmvg_div_cell u_div (
            .clk      (clk),
            .en       (advance),
            .divisor  (divisor),
            .lane_in  (div_bus[g]),
            .lane_out (div_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Quadrant fold: cos a, sin a, cos A, sin A
    // ------------------------------------------------------------------
    logic [TRIG_LANES-1:0][PHASE_W-1:0] phase;
    logic [TRIG_LANES-1:0][14:0]        u_c;
    logic [TRIG_LANES-1:0][30:0]        t0_t_reg;
    logic [TRIG_LANES-1:0]              t0_neg_reg;

    always_comb
    begin
        phase[0] = div_bus[DIV_STEPS][0].low + PHASE_W'(QUARTER_TURN);
        phase[1] = div_bus[DIV_STEPS][0].low;
        phase[2] = div_bus[DIV_STEPS][1].low + PHASE_W'(QUARTER_TURN);
        phase[3] = div_bus[DIV_STEPS][1].low;
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            if (phase[l][14])
                u_c[l] = 15'(QUARTER_TURN) - {1'b0, phase[l][13:0]};
            else
                u_c[l] = {1'b0, phase[l][13:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < TRIG_LANES; l++)
            begin
                t0_t_reg[l]   <= {u_c[l], 16'b0};
                t0_neg_reg[l] <= phase[l][15];
            end
        end
    end

    // Square the argument and seed the series
    trig_lane_t [TRIG_LANES-1:0] hb [HORNER_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < TRIG_LANES; l++)
            begin
                hb[0][l].t   <= t0_t_reg[l];
                hb[0][l].t2  <= 31'((62'(t0_t_reg[l]) * 62'(t0_t_reg[l])) >> COEF_SHIFT);
                hb[0][l].acc <= SINE_COEF[HORNER_STEPS];
                hb[0][l].neg <= t0_neg_reg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner chain
    // ------------------------------------------------------------------
    for (genvar g = 0; g < HORNER_STEPS; g++)
    begin : g_horner
        tmvg_horner_cell u_horner (
            .clk      (clk),
            .en       (advance),
            .coef     (SINE_COEF[HORNER_STEPS-1-g]),
            .lane_in  (hb[g]),
            .lane_out (hb[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Final multiply, rounding and sign
    // ------------------------------------------------------------------
    logic [TRIG_LANES-1:0][32:0]        s_reg;
    logic [TRIG_LANES-1:0]              s_neg_reg;
    logic [TRIG_LANES-1:0][33:0]        s_rnd;
    logic [TRIG_LANES-1:0][F-1:0]       s_mag;
    logic signed [F:0]                  trig_c   [TRIG_LANES];
    logic signed [F:0]                  trig_reg [TRIG_LANES];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < TRIG_LANES; l++)
            begin
                s_reg[l] <= 33'((63'(hb[HORNER_STEPS][l].acc)
                                 * 63'(hb[HORNER_STEPS][l].t)) >> COEF_SHIFT);
                s_neg_reg[l] <= hb[HORNER_STEPS][l].neg;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            s_rnd[l] = (34'(s_reg[l]) + S_HALF) >> SH;
            s_mag[l] = (s_rnd[l] > 34'(TRIG_TOP)) ? TRIG_TOP : s_rnd[l][F-1:0];
            trig_c[l] = s_neg_reg[l] ? -$signed({1'b0, s_mag[l]})
                                      :  $signed({1'b0, s_mag[l]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < TRIG_LANES; l++)
                trig_reg[l] <= trig_c[l];
        end
    end

    // ------------------------------------------------------------------
    // Position arithmetic
    // ------------------------------------------------------------------
    logic signed [F+17:0] prod_r_reg;
    logic signed [F+17:0] prod_y_reg;
    logic signed [F:0]    cos_big1_reg;
    logic signed [F:0]    sin_big1_reg;
    logic signed [F:0]    cos_big2_reg;
    logic signed [F:0]    sin_big2_reg;
    logic signed [F+18:0] raw_c;
    logic signed [F+18:0] ysum_c;
    logic signed [25:0]   radial_reg;
    logic signed [PY_W-1:0] py2_reg;
    logic signed [PY_W-1:0] py3_reg;
    logic signed [F+26:0] px_prod_reg;
    logic signed [F+26:0] pz_prod_reg;
    logic signed [F+27:0] xsum_c;
    logic signed [F+27:0] zsum_c;

    // Scale cos a and sin a by the tube radius
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_r_reg   <= (F+18)'($signed({1'b0, minor_radius_reg})) * (F+18)'(trig_reg[0]);
            prod_y_reg   <= (F+18)'($signed({1'b0, minor_radius_reg})) * (F+18)'(trig_reg[1]);
            cos_big1_reg <= trig_reg[2];
            sin_big1_reg <= trig_reg[3];
        end
    end

    // Form the ring distance and round y
    always_comb
    begin
        raw_c  = $signed({3'b0, major_radius_reg, {F{1'b0}}}) + (F+19)'(prod_r_reg)
                 + $signed(R_HALF);
        ysum_c = (F+19)'(prod_y_reg) + $signed(Y_HALF);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            radial_reg   <= 26'(raw_c >>> (F - 8));
            py2_reg      <= PY_W'(ysum_c >>> F);
            cos_big2_reg <= cos_big1_reg;
            sin_big2_reg <= sin_big1_reg;
        end
    end

    // Project the ring distance onto x and z
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_prod_reg <= (F+27)'(radial_reg) * (F+27)'(cos_big2_reg);
            pz_prod_reg <= (F+27)'(radial_reg) * (F+27)'(sin_big2_reg);
            py3_reg     <= py2_reg;
        end
    end

    always_comb
    begin
        xsum_c = (F+28)'(px_prod_reg) + $signed(X_HALF);
        zsum_c = (F+28)'(pz_prod_reg) + $signed(X_HALF);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [PX_W-1:0] pos_x_reg;
    logic signed [PY_W-1:0] pos_y_reg;
    logic signed [PX_W-1:0] pos_z_reg;
    side_t                  side_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_out_reg <= side_reg[LAST-1];
            if (side_reg[LAST-1].in_range)
            begin
                pos_x_reg <= PX_W'(xsum_c >>> (F + 8));
                pos_y_reg <= py3_reg;
                pos_z_reg <= PX_W'(zsum_c >>> (F + 8));
            end
            else
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end
        end
    end

    assign out_valid        = vld_reg[LAST];
    assign pos_x            = pos_x_reg;
    assign pos_y            = pos_y_reg;
    assign pos_z            = pos_z_reg;
    assign self_index       = side_out_reg.self_idx;
    assign next_minor_index = side_out_reg.next_minor;
    assign next_major_index = side_out_reg.next_major;
    assign next_both_index  = side_out_reg.next_both;
    assign in_range         = side_out_reg.in_range;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TMVG_ASSERT(a_out_of_range_zero, clk, rst_n, out_valid && !in_range |-> (pos_x == '0 && pos_y == '0 && pos_z == '0 && self_index == '0 && next_both_index == '0), "out-of-range vertex carries nonzero fields")
    `TMVG_ASSERT(a_transfer_enters, clk, rst_n, in_valid && in_ready |=> vld_reg[0], "accepted transfer did not enter the pipeline")
    `TMVG_ASSERT(a_stall_holds, clk, rst_n, !advance |=> ($stable(out_valid) && $stable(self_index) && $stable(pos_x)), "stalled result changed")
    `TMVG_ASSERT_NEVER(a_no_overrun, clk, rst_n, in_ready && out_valid && !out_ready, "input taken while output blocked")

endmodule

FILE: hdl/tmvg_div_cell.sv
// ----------------------------------------------------------------------------
// Phase divider cell
// One restoring division step per lane; a row of these forms the phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmvg_div_cell (
    input  logic                                                   clk,
    input  logic                                                   en,
    input  logic [tmvg_pkg::DIV_LANES-1:0][tmvg_pkg::CNT_W-1:0]    divisor,
    input  tmvg_pkg::div_lane_t [tmvg_pkg::DIV_LANES-1:0]          lane_in,
    output tmvg_pkg::div_lane_t [tmvg_pkg::DIV_LANES-1:0]          lane_out
);
    import tmvg_pkg::*;

    div_lane_t [DIV_LANES-1:0]         lane_reg;
    div_lane_t [DIV_LANES-1:0]         lane_next;
    logic [DIV_LANES-1:0][REM_W:0]     trial;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            trial[l] = {lane_in[l].rem, lane_in[l].low[PHASE_W-1]};
            if (trial[l] >= {1'b0, divisor[l]})
            begin
                lane_next[l].rem = REM_W'(trial[l] - {1'b0, divisor[l]});
                lane_next[l].low = {lane_in[l].low[PHASE_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[l].rem = trial[l][REM_W-1:0];
                lane_next[l].low = {lane_in[l].low[PHASE_W-2:0], 1'b0};
            end
        end
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: hdl/tmvg_horner_cell.sv
// ----------------------------------------------------------------------------
// Sine Horner cell
// One Horner step of the sine series for every trig lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmvg_horner_cell (
    input  logic                                           clk,
    input  logic                                           en,
    input  logic [31:0]                                    coef,
    input  tmvg_pkg::trig_lane_t [tmvg_pkg::TRIG_LANES-1:0] lane_in,
    output tmvg_pkg::trig_lane_t [tmvg_pkg::TRIG_LANES-1:0] lane_out
);
    import tmvg_pkg::*;

    trig_lane_t [TRIG_LANES-1:0]   lane_reg;
    trig_lane_t [TRIG_LANES-1:0]   lane_next;
    logic [TRIG_LANES-1:0][62:0]   prod;

    // Fold in one coefficient: coef - acc * t^2
    always_comb
    begin
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            prod[l]          = 63'(lane_in[l].acc) * 63'(lane_in[l].t2);
            lane_next[l]     = lane_in[l];
            lane_next[l].acc = coef - 32'(prod[l] >> COEF_SHIFT);
        end
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
